### design/drp_pkg.sv
package drp_pkg;

    localparam int PACKET_BYTES_DEF = 2048;

    // Configuration register indexes.
    localparam logic [2:0] CFG_MATCH_KEY        = 3'd0;
    localparam logic [2:0] CFG_MATCH_KEY_LEN    = 3'd1;
    localparam logic [2:0] CFG_MATCH_VALUE_HIGH = 3'd2;
    localparam logic [2:0] CFG_MATCH_VALUE_LOW  = 3'd3;
    localparam logic [2:0] CFG_MATCH_VALUE_LEN  = 3'd4;

    // Resource record types that get decoded.
    localparam logic [15:0] RR_TYPE_A    = 16'd1;
    localparam logic [15:0] RR_TYPE_PTR  = 16'd12;
    localparam logic [15:0] RR_TYPE_TXT  = 16'd16;
    localparam logic [15:0] RR_TYPE_AAAA = 16'd28;
    localparam logic [15:0] RR_TYPE_SRV  = 16'd33;
    localparam logic [15:0] RR_TYPE_NSEC = 16'd47;

    localparam logic [15:0] FLAG_RESPONSE_MASK  = 16'h8400;
    localparam logic [15:0] FLAG_TRUNCATED_MASK = 16'h0200;
    localparam logic [1:0]  LABEL_PLAIN         = 2'b00;
    localparam logic [1:0]  LABEL_POINTER       = 2'b11;
    localparam logic [7:0]  TXT_SEPARATOR       = 8'h3d;
    localparam logic [4:0]  MAX_VALUE_LEN       = 5'd16;
    localparam logic [3:0]  MAX_KEY_LEN         = 4'd8;
    localparam logic [4:0]  AAAA_BYTES          = 5'd16;

    typedef struct packed {
        logic [63:0] match_key;
        logic [3:0]  match_key_len;
        logic [63:0] match_value_high;
        logic [63:0] match_value_low;
        logic [4:0]  match_value_len;
    } cfg_t;

    // Release of a packet bank by the parser.
    typedef struct packed {
        logic valid;
        logic bank;
    } done_t;

endpackage

### design/drp_front.sv
module drp_front
    import drp_pkg::*;
#(
    parameter int PACKET_BYTES = PACKET_BYTES_DEF,
    localparam int CNT_W  = $clog2(PACKET_BYTES + 1),
    localparam int MEM_AW = $clog2(2 * PACKET_BYTES),
    localparam int JOB_W  = CNT_W + 2
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_packet_byte,
    input  logic              s_last_byte,
    output logic              q_push,
    output logic [JOB_W-1:0]  q_data,
    input  logic              q_full,
    input  done_t             done,
    input  logic              rd_en,
    input  logic [MEM_AW-1:0] rd_addr,
    output logic [7:0]        rd_data
);

    logic [7:0]       mem [2*PACKET_BYTES];
    logic [7:0]       rd_data_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic             fill_reg;
    logic [1:0]       busy_reg, busy_next;
    logic             accept, room;
    logic [MEM_AW-1:0] wr_addr;

    assign s_ready = !busy_reg[fill_reg] && !q_full;
    assign accept  = s_valid && s_ready;
    assign room    = count_reg < CNT_W'(PACKET_BYTES);
    assign wr_addr = fill_reg ? MEM_AW'(PACKET_BYTES) + MEM_AW'(count_reg) : MEM_AW'(count_reg);

    always_comb begin
        count_next = room ? count_reg + CNT_W'(1) : count_reg;
        ovf_next   = ovf_reg || !room;
        busy_next  = busy_reg;
        if (done.valid) begin
            busy_next[done.bank] = 1'b0;
        end
        if (accept && s_last_byte) begin
            busy_next[fill_reg] = 1'b1;
        end
    end

    assign q_push = accept && s_last_byte;
    assign q_data = {fill_reg, ovf_next, count_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            fill_reg  <= 1'b0;
            busy_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            if (accept) begin
                if (s_last_byte) begin
                    count_reg <= '0;
                    ovf_reg   <= 1'b0;
                    fill_reg  <= !fill_reg;
                end else begin
                    count_reg <= count_next;
                    ovf_reg   <= ovf_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && room) begin
            mem[wr_addr] <= s_packet_byte;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### design/drp_queue.sv
module drp_queue
    import drp_pkg::*;
#(
    parameter int PACKET_BYTES = PACKET_BYTES_DEF,
    localparam int JOB_W = $clog2(PACKET_BYTES + 1) + 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [JOB_W-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [JOB_W-1:0] dout,
    output logic             empty
);

    logic [JOB_W-1:0] slot_reg [2];
    logic             wr_ptr_reg, rd_ptr_reg;
    logic [1:0]       fill_reg;

    assign full  = fill_reg == 2'd2;
    assign empty = fill_reg == 2'd0;
    assign dout  = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= '0;
        end else begin
            if (push && !full) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop && !empty) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            fill_reg <= fill_reg + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
        end
    end

    always_ff @(posedge aclk) begin
        if (push && !full) begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

### design/drp_back.sv
module drp_back
    import drp_pkg::*;
#(
    parameter int PACKET_BYTES = PACKET_BYTES_DEF,
    localparam int CNT_W  = $clog2(PACKET_BYTES + 1),
    localparam int POS_W  = $clog2(PACKET_BYTES + 2),
    localparam int MEM_AW = $clog2(2 * PACKET_BYTES),
    localparam int JOB_W  = CNT_W + 2,
    localparam int WIDE   = ((POS_W > 16) ? POS_W : 16) + 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  cfg_t              cfg,
    input  logic [JOB_W-1:0]  q_dout,
    input  logic              q_empty,
    output logic              q_pop,
    output done_t             done,
    output logic              rd_en,
    output logic [MEM_AW-1:0] rd_addr,
    input  logic [7:0]        rd_data,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_parse_ok,
    output logic [15:0]       m_transaction_id,
    output logic              m_is_response,
    output logic              m_is_truncated,
    output logic [15:0]       m_service_port,
    output logic              m_attribute_match,
    output logic              m_too_long
);

    typedef enum logic [4:0] {
        S_IDLE, S_RD_ISSUE, S_RD_WAIT, S_HDR, S_REC_NEXT, S_NAME_START, S_NAME_LABEL,
        S_NAME_PTR, S_REC_HDR, S_REC_TYPE, S_REC_DLEN, S_NSEC_NAME, S_NSEC_HDR,
        S_SRV_PORT, S_SRV_END, S_TXT_LOOP, S_TXT_LEN, S_TXT_BYTE, S_TXT_ENTRY,
        S_TXT_END, S_REC_DONE, S_OUT
    } state_t;

    state_t           state_reg, ret_reg, name_ret_reg;
    logic [3:0]       rd_left_reg;
    logic [15:0]      acc_reg;
    logic             bank_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [POS_W-1:0] pos_reg, limit_reg, resume_reg;
    logic             resume_valid_reg;
    logic [2:0]       hdr_idx_reg;
    logic [15:0]      id_reg, rec_left_reg, type_reg, dlen_reg, port_reg;
    logic             resp_reg, trunc_reg, match_reg, ok_reg, long_reg;
    logic [WIDE-1:0]  txt_end_reg;
    logic             key_seen_reg, value_ok_reg;
    logic [7:0]       ent_len_reg, idx_reg, klen_reg, vidx_reg;
    logic             eq_seen_reg, key_ok_reg, val_ok_reg;

    logic             m_valid_reg, res_ok_reg, res_resp_reg, res_trunc_reg;
    logic             res_match_reg, res_long_reg;
    logic [15:0]      res_id_reg, res_port_reg;

    logic [WIDE-1:0]  pos_w, cnt_w;
    logic [13:0]      target;
    logic [7:0]       klen_eff;
    logic             key_hit, val_hit, out_free;

    function automatic logic [7:0] key_sel(input logic [63:0] w, input logic [2:0] i);
        key_sel = w[8*(7-i) +: 8];
    endfunction

    function automatic logic [7:0] val_sel(input cfg_t c, input logic [3:0] j);
        logic [63:0] w;
        w = j[3] ? c.match_value_low : c.match_value_high;
        val_sel = w[8*(7-j[2:0]) +: 8];
    endfunction

    assign pos_w    = WIDE'(pos_reg);
    assign cnt_w    = WIDE'(cnt_reg);
    assign target   = {acc_reg[13:8], acc_reg[7:0]};
    assign out_free = !m_valid_reg || m_ready;

    assign klen_eff = eq_seen_reg ? klen_reg : ent_len_reg;
    assign key_hit  = (cfg.match_key_len != 4'd0) && (cfg.match_key_len <= MAX_KEY_LEN)
                      && (klen_eff == 8'(cfg.match_key_len)) && key_ok_reg;
    assign val_hit  = eq_seen_reg
                      ? ((cfg.match_value_len <= MAX_VALUE_LEN)
                         && (vidx_reg == 8'(cfg.match_value_len)) && val_ok_reg)
                      : (cfg.match_value_len == 5'd0);

    assign q_pop      = (state_reg == S_IDLE) && !q_empty;
    assign done.valid = (state_reg == S_OUT) && out_free;
    assign done.bank  = bank_reg;
    assign rd_en      = (state_reg == S_RD_ISSUE) && (pos_w < cnt_w);
    assign rd_addr    = bank_reg ? MEM_AW'(PACKET_BYTES) + MEM_AW'(pos_reg)
                                 : MEM_AW'(pos_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            // In S_OUT the result register is reloaded below whenever it is free.
            if (m_valid_reg && m_ready && state_reg != S_OUT) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (!q_empty) begin
                        cnt_reg      <= q_dout[CNT_W-1:0];
                        bank_reg     <= q_dout[JOB_W-1];
                        pos_reg      <= '0;
                        port_reg     <= '0;
                        match_reg    <= 1'b0;
                        long_reg     <= q_dout[CNT_W];
                        ok_reg       <= 1'b0;
                        hdr_idx_reg  <= '0;
                        if (q_dout[CNT_W]) begin
                            state_reg <= S_OUT;
                        end else begin
                            rd_left_reg <= 4'd2;
                            ret_reg     <= S_HDR;
                            state_reg   <= S_RD_ISSUE;
                        end
                    end
                end
                // Every byte that the parser reads is fetched through this pair of states.
                S_RD_ISSUE: begin
                    if (pos_w >= cnt_w) begin
                        ok_reg    <= 1'b0;
                        state_reg <= S_OUT;
                    end else begin
                        pos_reg   <= pos_reg + POS_W'(1);
                        state_reg <= S_RD_WAIT;
                    end
                end
                S_RD_WAIT: begin
                    acc_reg <= {acc_reg[7:0], rd_data};
                    if (rd_left_reg == 4'd1) begin
                        state_reg <= ret_reg;
                    end else begin
                        rd_left_reg <= rd_left_reg - 4'd1;
                        state_reg   <= S_RD_ISSUE;
                    end
                end
                S_HDR: begin
                    case (hdr_idx_reg)
                        3'd0: id_reg <= acc_reg;
                        3'd1: begin
                            resp_reg  <= |(acc_reg & FLAG_RESPONSE_MASK);
                            trunc_reg <= |(acc_reg & FLAG_TRUNCATED_MASK);
                        end
                        3'd3: rec_left_reg <= acc_reg;
                        3'd4, 3'd5: rec_left_reg <= rec_left_reg + acc_reg;
                        default: ;
                    endcase
                    if (hdr_idx_reg == 3'd5) begin
                        state_reg <= S_REC_NEXT;
                    end else begin
                        hdr_idx_reg <= hdr_idx_reg + 3'd1;
                        rd_left_reg <= 4'd2;
                        ret_reg     <= S_HDR;
                        state_reg   <= S_RD_ISSUE;
                    end
                end
                S_REC_NEXT: begin
                    if (rec_left_reg == 16'd0) begin
                        ok_reg    <= 1'b1;
                        state_reg <= S_OUT;
                    end else begin
                        name_ret_reg <= S_REC_HDR;
                        state_reg    <= S_NAME_START;
                    end
                end
                S_NAME_START: begin
                    limit_reg        <= pos_reg;
                    resume_valid_reg <= 1'b0;
                    rd_left_reg      <= 4'd1;
                    ret_reg          <= S_NAME_LABEL;
                    state_reg        <= S_RD_ISSUE;
                end
                S_NAME_LABEL: begin
                    if (acc_reg[7:0] == 8'd0) begin
                        if (resume_valid_reg) begin
                            pos_reg <= resume_reg;
                        end
                        state_reg <= name_ret_reg;
                    end else if (acc_reg[7:6] == LABEL_PLAIN) begin
                        if (pos_w + WIDE'(acc_reg[7:0]) > cnt_w) begin
                            ok_reg    <= 1'b0;
                            state_reg <= S_OUT;
                        end else begin
                            pos_reg     <= pos_reg + POS_W'(acc_reg[7:0]);
                            rd_left_reg <= 4'd1;
                            ret_reg     <= S_NAME_LABEL;
                            state_reg   <= S_RD_ISSUE;
                        end
                    end else if (acc_reg[7:6] == LABEL_POINTER) begin
                        rd_left_reg <= 4'd1;
                        ret_reg     <= S_NAME_PTR;
                        state_reg   <= S_RD_ISSUE;
                    end else begin
                        ok_reg    <= 1'b0;
                        state_reg <= S_OUT;
                    end
                end
                // A compression pointer must land strictly before the name start or the last target.
                S_NAME_PTR: begin
                    if (WIDE'(target) >= WIDE'(limit_reg)) begin
                        ok_reg    <= 1'b0;
                        state_reg <= S_OUT;
                    end else begin
                        limit_reg <= POS_W'(target);
                        if (!resume_valid_reg) begin
                            resume_valid_reg <= 1'b1;
                            resume_reg       <= pos_reg;
                        end
                        pos_reg     <= POS_W'(target);
                        rd_left_reg <= 4'd1;
                        ret_reg     <= S_NAME_LABEL;
                        state_reg   <= S_RD_ISSUE;
                    end
                end
                S_REC_HDR: begin
                    rd_left_reg <= 4'd2;
                    ret_reg     <= S_REC_TYPE;
                    state_reg   <= S_RD_ISSUE;
                end
                S_REC_TYPE: begin
                    // Class and TTL are read and dropped together with the data length.
                    type_reg    <= acc_reg;
                    rd_left_reg <= 4'd8;
                    ret_reg     <= S_REC_DLEN;
                    state_reg   <= S_RD_ISSUE;
                end
                S_REC_DLEN: begin
                    dlen_reg <= acc_reg;
                    case (type_reg)
                        RR_TYPE_A: begin
                            rd_left_reg <= 4'd4;
                            ret_reg     <= S_REC_DONE;
                            state_reg   <= S_RD_ISSUE;
                        end
                        RR_TYPE_AAAA: begin
                            if (pos_w + WIDE'(AAAA_BYTES) > cnt_w) begin
                                ok_reg    <= 1'b0;
                                state_reg <= S_OUT;
                            end else begin
                                pos_reg   <= pos_reg + POS_W'(AAAA_BYTES);
                                state_reg <= S_REC_DONE;
                            end
                        end
                        RR_TYPE_NSEC: begin
                            name_ret_reg <= S_NSEC_NAME;
                            state_reg    <= S_NAME_START;
                        end
                        RR_TYPE_PTR: begin
                            name_ret_reg <= S_REC_DONE;
                            state_reg    <= S_NAME_START;
                        end
                        RR_TYPE_SRV: begin
                            rd_left_reg <= 4'd6;
                            ret_reg     <= S_SRV_PORT;
                            state_reg   <= S_RD_ISSUE;
                        end
                        RR_TYPE_TXT: begin
                            txt_end_reg  <= pos_w + WIDE'(acc_reg);
                            key_seen_reg <= 1'b0;
                            value_ok_reg <= 1'b0;
                            state_reg    <= S_TXT_LOOP;
                        end
                        default: begin
                            // A skip past the end parks the position beyond the data.
                            if (pos_w + WIDE'(acc_reg) > cnt_w) begin
                                pos_reg <= POS_W'(cnt_reg) + POS_W'(1);
                            end else begin
                                pos_reg <= pos_reg + POS_W'(acc_reg);
                            end
                            state_reg <= S_REC_DONE;
                        end
                    endcase
                end
                S_NSEC_NAME: begin
                    rd_left_reg <= 4'd2;
                    ret_reg     <= S_NSEC_HDR;
                    state_reg   <= S_RD_ISSUE;
                end
                S_NSEC_HDR: begin
                    if (acc_reg[15:8] != 8'd0 || pos_w + WIDE'(acc_reg[7:0]) > cnt_w) begin
                        ok_reg    <= 1'b0;
                        state_reg <= S_OUT;
                    end else begin
                        pos_reg   <= pos_reg + POS_W'(acc_reg[7:0]);
                        state_reg <= S_REC_DONE;
                    end
                end
                S_SRV_PORT: begin
                    dlen_reg     <= acc_reg;
                    name_ret_reg <= S_SRV_END;
                    state_reg    <= S_NAME_START;
                end
                S_SRV_END: begin
                    if (dlen_reg != 16'd0) begin
                        port_reg <= dlen_reg;
                    end
                    state_reg <= S_REC_DONE;
                end
                S_TXT_LOOP: begin
                    if (pos_w < txt_end_reg) begin
                        rd_left_reg <= 4'd1;
                        ret_reg     <= S_TXT_LEN;
                        state_reg   <= S_RD_ISSUE;
                    end else begin
                        state_reg <= S_TXT_END;
                    end
                end
                S_TXT_LEN: begin
                    if (pos_w + WIDE'(acc_reg[7:0]) > cnt_w) begin
                        ok_reg    <= 1'b0;
                        state_reg <= S_OUT;
                    end else if (acc_reg[7:0] == 8'd0) begin
                        state_reg <= S_TXT_END;
                    end else begin
                        ent_len_reg <= acc_reg[7:0];
                        idx_reg     <= '0;
                        klen_reg    <= '0;
                        vidx_reg    <= '0;
                        eq_seen_reg <= 1'b0;
                        key_ok_reg  <= 1'b1;
                        val_ok_reg  <= 1'b1;
                        rd_left_reg <= 4'd1;
                        ret_reg     <= S_TXT_BYTE;
                        state_reg   <= S_RD_ISSUE;
                    end
                end
                S_TXT_BYTE: begin
                    if (!eq_seen_reg) begin
                        if (acc_reg[7:0] == TXT_SEPARATOR) begin
                            eq_seen_reg <= 1'b1;
                            klen_reg    <= idx_reg;
                        end else if (idx_reg >= 8'd8
                                     || acc_reg[7:0] != key_sel(cfg.match_key, idx_reg[2:0])) begin
                            key_ok_reg <= 1'b0;
                        end
                    end else begin
                        if (vidx_reg >= 8'(MAX_VALUE_LEN)
                            || acc_reg[7:0] != val_sel(cfg, vidx_reg[3:0])) begin
                            val_ok_reg <= 1'b0;
                        end
                        vidx_reg <= vidx_reg + 8'd1;
                    end
                    if (9'(idx_reg) + 9'd1 == 9'(ent_len_reg)) begin
                        state_reg <= S_TXT_ENTRY;
                    end else begin
                        idx_reg     <= idx_reg + 8'd1;
                        rd_left_reg <= 4'd1;
                        ret_reg     <= S_TXT_BYTE;
                        state_reg   <= S_RD_ISSUE;
                    end
                end
                S_TXT_ENTRY: begin
                    if (key_hit) begin
                        key_seen_reg <= 1'b1;
                        value_ok_reg <= val_hit;
                    end
                    state_reg <= S_TXT_LOOP;
                end
                S_TXT_END: begin
                    if (key_seen_reg && value_ok_reg) begin
                        match_reg <= 1'b1;
                    end
                    state_reg <= S_REC_DONE;
                end
                S_REC_DONE: begin
                    rec_left_reg <= rec_left_reg - 16'd1;
                    state_reg    <= S_REC_NEXT;
                end
                S_OUT: begin
                    if (out_free) begin
                        m_valid_reg   <= 1'b1;
                        res_ok_reg    <= ok_reg;
                        res_id_reg    <= ok_reg ? id_reg : 16'd0;
                        res_resp_reg  <= ok_reg && resp_reg;
                        res_trunc_reg <= ok_reg && trunc_reg;
                        res_port_reg  <= ok_reg ? port_reg : 16'd0;
                        res_match_reg <= ok_reg && match_reg;
                        res_long_reg  <= long_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_parse_ok        = res_ok_reg;
    assign m_transaction_id  = res_id_reg;
    assign m_is_response     = res_resp_reg;
    assign m_is_truncated    = res_trunc_reg;
    assign m_service_port    = res_port_reg;
    assign m_attribute_match = res_match_reg;
    assign m_too_long        = res_long_reg;

endmodule

### design/dns_response_parser_unit.sv
// Channel     | Handshake         | Payload
// ------------+-------------------+---------------------------------------------
// input       | s_valid / s_ready | s_packet_byte, s_last_byte
// result      | m_valid / m_ready | m_parse_ok, m_transaction_id, m_is_response,
//             |                   | m_is_truncated, m_service_port,
//             |                   | m_attribute_match, m_too_long
// config      | cfg_wr_en         | cfg_index, cfg_wdata
//
// Bytes load one per cycle into one of two packet banks; the next datagram loads
// into the other bank while the parser works. Each byte the parser reads goes
// through the registered memory read port, issued in S_RD_ISSUE and taken in
// S_RD_WAIT; header fields, labels, pointers, records and TXT entries add states
// of their own. Skipped data costs no reads. Reset is synchronous and needs no
// clearing pass. The input stalls only while both banks hold datagrams; a waiting
// result stalls the parser, not the loader.
module dns_response_parser_unit
    import drp_pkg::*;
#(
    parameter int PACKET_BYTES = PACKET_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_packet_byte,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_parse_ok,
    output logic [15:0] m_transaction_id,
    output logic        m_is_response,
    output logic        m_is_truncated,
    output logic [15:0] m_service_port,
    output logic        m_attribute_match,
    output logic        m_too_long,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_wdata
);

    localparam int CNT_W  = $clog2(PACKET_BYTES + 1);
    localparam int MEM_AW = $clog2(2 * PACKET_BYTES);
    localparam int JOB_W  = CNT_W + 2;

    cfg_t              cfg_reg;
    logic              q_push, q_full, q_pop, q_empty;
    logic [JOB_W-1:0]  q_din, q_dout;
    done_t             done;
    logic              rd_en;
    logic [MEM_AW-1:0] rd_addr;
    logic [7:0]        rd_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_MATCH_KEY:        cfg_reg.match_key        <= cfg_wdata;
                CFG_MATCH_KEY_LEN:    cfg_reg.match_key_len    <= cfg_wdata[3:0];
                CFG_MATCH_VALUE_HIGH: cfg_reg.match_value_high <= cfg_wdata;
                CFG_MATCH_VALUE_LOW:  cfg_reg.match_value_low  <= cfg_wdata;
                CFG_MATCH_VALUE_LEN:  cfg_reg.match_value_len  <= cfg_wdata[4:0];
                default: ;
            endcase
        end
    end

    drp_front #(.PACKET_BYTES(PACKET_BYTES)) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_packet_byte (s_packet_byte),
        .s_last_byte   (s_last_byte),
        .q_push        (q_push),
        .q_data        (q_din),
        .q_full        (q_full),
        .done          (done),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data)
    );

    drp_queue #(.PACKET_BYTES(PACKET_BYTES)) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .din     (q_din),
        .full    (q_full),
        .pop     (q_pop),
        .dout    (q_dout),
        .empty   (q_empty)
    );

    drp_back #(.PACKET_BYTES(PACKET_BYTES)) u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg               (cfg_reg),
        .q_dout            (q_dout),
        .q_empty           (q_empty),
        .q_pop             (q_pop),
        .done              (done),
        .rd_en             (rd_en),
        .rd_addr           (rd_addr),
        .rd_data           (rd_data),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_parse_ok        (m_parse_ok),
        .m_transaction_id  (m_transaction_id),
        .m_is_response     (m_is_response),
        .m_is_truncated    (m_is_truncated),
        .m_service_port    (m_service_port),
        .m_attribute_match (m_attribute_match),
        .m_too_long        (m_too_long)
    );

endmodule

### design/drp_checker.sv
module drp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_parse_ok,
    input logic [15:0] m_transaction_id,
    input logic        m_is_response,
    input logic        m_is_truncated,
    input logic [15:0] m_service_port,
    input logic        m_attribute_match,
    input logic        m_too_long
);

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_transaction_id) && $stable(m_parse_ok))
        else $error("result changed while stalled");

    a_long_fails: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_too_long |-> !m_parse_ok)
        else $error("oversize datagram reported as parsed");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_parse_ok |-> m_transaction_id == 16'd0 && m_service_port == 16'd0
            && !m_is_response && !m_is_truncated && !m_attribute_match)
        else $error("failed parse carries nonzero fields");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind dns_response_parser_unit drp_checker u_drp_checker (.*);

### dv/tb_top.sv
module tb_top;
    import drp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_BYTES = PACKET_BYTES_DEF;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct {
        logic [7:0] data;
        logic       last;
        bit         hold;
    } byte_item_t;

    typedef struct {
        bit          ok;
        logic [15:0] id;
        bit          resp;
        bit          trunc;
        logic [15:0] port;
        bit          attr;
        bit          too_long;
    } dns_result_t;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_valid = 0;
    logic        s_ready;
    logic [7:0]  s_packet_byte = 0;
    logic        s_last_byte = 0;
    logic        m_valid;
    logic        m_ready = 0;
    logic        m_parse_ok;
    logic [15:0] m_transaction_id;
    logic        m_is_response;
    logic        m_is_truncated;
    logic [15:0] m_service_port;
    logic        m_attribute_match;
    logic        m_too_long;
    logic        cfg_wr_en = 0;
    logic [2:0]  cfg_index = 0;
    logic [63:0] cfg_wdata = 0;

    dns_response_parser_unit u_dut (.*);

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Register mirror.
    logic [63:0] key_reg = 0;
    logic [3:0]  key_len_reg = 0;
    logic [63:0] val_hi_reg = 0;
    logic [63:0] val_lo_reg = 0;
    logic [4:0]  val_len_reg = 0;

    byte_item_t  tx_q[$];
    logic [7:0]  rx_bytes[$];
    dns_result_t pending_results[$];
    int          fail_count = 0;
    int          datagrams_sent = 0;
    int          results_seen = 0;
    int          ok_seen = 0;
    int          match_seen = 0;
    bit          quiet = 0;
    int          send_gap = 0;
    int          recv_gap = 0;
    int          cycles = 0;

    // ---------------------------------------------------------------- parser model
    int pcnt, ppos, plimit, pport;
    bit pmatch;

    function automatic bit take_bytes(int n, output int v);
        v = 0;
        if (ppos > pcnt || n > pcnt - ppos) return 0;
        for (int i = 0; i < n; i++) v = (v << 8) | rx_bytes[ppos + i];
        ppos += n;
        return 1;
    endfunction

    function automatic bit room_for(int n);
        return ppos <= pcnt && n <= pcnt - ppos;
    endfunction

    function automatic bit walk_name();
        bit jumped;
        int c, c2, tgt, resume;
        jumped = 0;
        resume = 0;
        plimit = ppos;
        while (1) begin
            if (!take_bytes(1, c)) return 0;
            if (c == 0) break;
            if (c[7:6] == LABEL_PLAIN) begin
                if (!room_for(c)) return 0;
                ppos += c;
            end else if (c[7:6] == LABEL_POINTER) begin
                if (!take_bytes(1, c2)) return 0;
                tgt = ((c & 'h3f) << 8) | c2;
                if (tgt >= plimit) return 0;
                plimit = tgt;
                if (!jumped) begin
                    jumped = 1;
                    resume = ppos;
                end
                ppos = tgt;
            end else begin
                return 0;
            end
        end
        if (jumped) ppos = resume;
        return 1;
    endfunction

    function automatic logic [7:0] key_at(int i);
        return key_reg[63 - 8 * (i & 7) -: 8];
    endfunction

    function automatic logic [7:0] value_at(int i);
        logic [63:0] w;
        w = (i < 8) ? val_hi_reg : val_lo_reg;
        return w[63 - 8 * (i & 7) -: 8];
    endfunction

    function automatic bit value_matches(int at, int len);
        if (val_len_reg > MAX_VALUE_LEN || len != int'(val_len_reg)) return 0;
        for (int i = 0; i < len; i++)
            if (rx_bytes[at + i] != value_at(i)) return 0;
        return 1;
    endfunction

    function automatic bit walk_txt(int dlen);
        int stop, n, klen;
        bit key_seen, val_ok, keq, key_on;
        stop = ppos + dlen;
        key_seen = 0;
        val_ok = 0;
        key_on = key_len_reg != 0 && key_len_reg <= MAX_KEY_LEN;
        while (ppos < stop) begin
            if (!take_bytes(1, n) || !room_for(n)) return 0;
            if (n == 0) break;
            klen = n;
            for (int i = 0; i < n; i++)
                if (rx_bytes[ppos + i] == TXT_SEPARATOR) begin
                    klen = i;
                    break;
                end
            keq = key_on && klen == int'(key_len_reg);
            for (int i = 0; keq && i < klen; i++)
                if (rx_bytes[ppos + i] != key_at(i)) keq = 0;
            if (keq) begin
                key_seen = 1;
                if (klen < n) val_ok = value_matches(ppos + klen + 1, n - klen - 1);
                else val_ok = (val_len_reg == 0);
            end
            ppos += n;
        end
        if (key_seen && val_ok) pmatch = 1;
        return 1;
    endfunction

    function automatic bit walk_record();
        int typ, cls, ttl, dlen, v, num, len;
        if (!walk_name() || !take_bytes(2, typ) || !take_bytes(2, cls) ||
            !take_bytes(4, ttl) || !take_bytes(2, dlen))
            return 0;
        case (16'(typ))
            RR_TYPE_A:    return take_bytes(4, v);
            RR_TYPE_AAAA: begin
                if (!room_for(AAAA_BYTES)) return 0;
                ppos += AAAA_BYTES;
                return 1;
            end
            RR_TYPE_NSEC: begin
                if (!walk_name() || !take_bytes(1, num) || !take_bytes(1, len) ||
                    num != 0 || !room_for(len))
                    return 0;
                ppos += len;
                return 1;
            end
            RR_TYPE_PTR:  return walk_name();
            RR_TYPE_SRV: begin
                if (!take_bytes(2, v) || !take_bytes(2, v) || !take_bytes(2, num) ||
                    !walk_name())
                    return 0;
                if (num != 0) pport = num;
                return 1;
            end
            RR_TYPE_TXT:  return walk_txt(dlen);
            default: begin
                if (ppos > pcnt || dlen > pcnt - ppos) ppos = pcnt + 1;
                else ppos += dlen;
                return 1;
            end
        endcase
    endfunction

    function automatic dns_result_t predict_datagram();
        dns_result_t r;
        int id, flags, nq, na, nu, nd, left;
        bit ok;
        r = '{default: 0};
        if (rx_bytes.size() > STORE_BYTES) begin
            r.too_long = 1;
            return r;
        end
        pcnt = rx_bytes.size();
        ppos = 0;
        pport = 0;
        pmatch = 0;
        ok = take_bytes(2, id) && take_bytes(2, flags) && take_bytes(2, nq) &&
             take_bytes(2, na) && take_bytes(2, nu) && take_bytes(2, nd);
        if (ok) begin
            left = (na + nu + nd) & 'hffff;
            while (ok && left != 0) begin
                ok = walk_record();
                left--;
            end
        end
        if (ok) begin
            r.ok = 1;
            r.id = id[15:0];
            r.resp = (flags[15:0] & FLAG_RESPONSE_MASK) != 0;
            r.trunc = (flags[15:0] & FLAG_TRUNCATED_MASK) != 0;
            r.port = pport[15:0];
            r.attr = pmatch;
        end
        return r;
    endfunction

    // ---------------------------------------------------------------- datagram building
    task automatic put16(ref logic [7:0] q[$], input int v);
        q.push_back(v[15:8]);
        q.push_back(v[7:0]);
    endtask

    task automatic put_header(ref logic [7:0] q[$], input int id, input int flags,
                              input int nq, input int na, input int nu, input int nd);
        put16(q, id);
        put16(q, flags);
        put16(q, nq);
        put16(q, na);
        put16(q, nu);
        put16(q, nd);
    endtask

    task automatic put_name(ref logic [7:0] q[$], input bit noisy);
        int nl, ll, tgt;
        nl = $urandom_range(0, 3);
        for (int i = 0; i < nl; i++) begin
            if (noisy && $urandom_range(0, 11) == 0) begin
                q.push_back($urandom_range(0, 1) ? 8'(8'h40 | $urandom_range(0, 63))
                                                 : 8'(8'h80 | $urandom_range(0, 63)));
            end
            ll = $urandom_range(1, 6);
            q.push_back(ll[7:0]);
            for (int j = 0; j < ll; j++) q.push_back(8'(8'h61 + $urandom_range(0, 25)));
        end
        if (q.size() > 13 && $urandom_range(0, 2) == 0) begin
            if (noisy && $urandom_range(0, 7) == 0) tgt = q.size() + $urandom_range(0, 9);
            else if ($urandom_range(0, 1)) tgt = 12;
            else tgt = $urandom_range(0, q.size() - 1);
            q.push_back(8'hc0 | tgt[13:8]);
            q.push_back(tgt[7:0]);
        end else begin
            q.push_back(8'h00);
        end
    endtask

    task automatic put_txt_entry(ref logic [7:0] q[$]);
        int kind, n;
        kind = $urandom_range(0, 5);
        if (kind <= 2) begin
            // Configured key, then the wanted value, a key alone, or a spoiled value.
            n = key_len_reg + (kind == 1 ? 0 : 1 + val_len_reg);
            if (n > 255) n = 255;
            q.push_back(n[7:0]);
            for (int i = 0; i < key_len_reg; i++) q.push_back(key_at(i));
            if (kind != 1) begin
                q.push_back(TXT_SEPARATOR);
                for (int i = 0; i < val_len_reg; i++)
                    q.push_back(kind == 2 && i == 0 ? value_at(i) ^ 8'h01 : value_at(i));
            end
        end else if (kind == 3) begin
            q.push_back(8'h00);
        end else begin
            n = $urandom_range(1, 12);
            q.push_back(n[7:0]);
            for (int i = 0; i < n; i++)
                q.push_back($urandom_range(0, 3) == 0 ? TXT_SEPARATOR : 8'($urandom()));
        end
    endtask

    task automatic put_record(ref logic [7:0] q[$], input bit noisy);
        int sel, typ, at, len, v;
        logic [15:0] tlist[6];
        tlist = '{RR_TYPE_A, RR_TYPE_AAAA, RR_TYPE_NSEC, RR_TYPE_PTR, RR_TYPE_SRV, RR_TYPE_TXT};
        put_name(q, noisy);
        sel = $urandom_range(0, 7);
        if (sel < 6) typ = int'(tlist[sel]);
        else typ = $urandom_range(0, 65535);
        put16(q, typ);
        put16(q, 1);
        put16(q, $urandom());
        put16(q, $urandom());
        at = q.size();
        put16(q, 0);
        case (16'(typ))
            RR_TYPE_A:    repeat (4) q.push_back(8'($urandom()));
            RR_TYPE_AAAA: repeat (AAAA_BYTES) q.push_back(8'($urandom()));
            RR_TYPE_NSEC: begin
                put_name(q, noisy);
                q.push_back(noisy && $urandom_range(0, 5) == 0 ? 8'($urandom_range(1, 255))
                                                                : 8'h00);
                len = $urandom_range(1, 6);
                q.push_back(len[7:0]);
                repeat (len) q.push_back(8'($urandom()));
            end
            RR_TYPE_PTR:  put_name(q, noisy);
            RR_TYPE_SRV: begin
                put16(q, $urandom());
                put16(q, $urandom());
                put16(q, $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 65535));
                put_name(q, noisy);
            end
            RR_TYPE_TXT: begin
                v = $urandom_range(1, 4);
                repeat (v) put_txt_entry(q);
            end
            default: repeat ($urandom_range(0, 10)) q.push_back(8'($urandom()));
        endcase
        len = q.size() - at - 2;
        if (noisy && $urandom_range(0, 7) == 0) len = $urandom_range(0, 65535);
        q[at] = len[15:8];
        q[at + 1] = len[7:0];
    endtask

    task automatic queue_datagram(ref logic [7:0] q[$], input bit hold);
        for (int i = 0; i < q.size(); i++)
            tx_q.push_back('{data: q[i], last: i == q.size() - 1, hold: hold && i == 0});
    endtask

    task automatic random_datagram(input bit hold);
        logic [7:0] q[$];
        int na, nu, nd;
        bit noisy;
        noisy = $urandom_range(0, 3) == 0;
        na = $urandom_range(0, 3);
        nu = $urandom_range(0, 1);
        nd = $urandom_range(0, 2);
        put_header(q, $urandom(), $urandom(), $urandom_range(0, 2), na, nu, nd);
        repeat (na + nu + nd) put_record(q, noisy);
        if (noisy) begin
            if ($urandom_range(0, 1)) begin
                repeat ($urandom_range(1, 8)) if (q.size() > 1) void'(q.pop_back());
            end else begin
                q[$urandom_range(0, q.size() - 1)] = 8'($urandom());
            end
        end
        queue_datagram(q, hold);
    endtask

    task automatic directed_datagrams();
        logic [7:0] q[$];
        q = '{8'h5a};                                     // header cut to one byte
        queue_datagram(q, 0);
        q.delete();
        put_header(q, 16'hffff, 16'h0200, 1, 0, 0, 0);
        void'(q.pop_back());                              // header one byte short
        queue_datagram(q, 0);
        q.delete();
        put_header(q, 16'h0000, 16'h8400, 0, 0, 0, 0);
        queue_datagram(q, 0);
        q.delete();
        put_header(q, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 0, 1);  // counts wrap to zero
        queue_datagram(q, 0);
        q.delete();
        // Pointer that does not point backward.
        put_header(q, 16'h1234, 16'h8000, 0, 1, 0, 0);
        q.push_back(8'hc0);
        q.push_back(8'h0c);
        queue_datagram(q, 0);
        q.delete();
        // Reserved label types.
        put_header(q, 16'h1235, 16'h0400, 0, 0, 1, 0);
        q.push_back(8'h41);
        q.push_back(8'h00);
        queue_datagram(q, 0);
        q.delete();
        put_header(q, 16'h1236, 16'h0400, 0, 0, 0, 1);
        q.push_back(8'h81);
        q.push_back(8'h00);
        queue_datagram(q, 0);
        q.delete();
        // NSEC with a nonzero window number.
        put_header(q, 16'h2000, 16'h8400, 0, 1, 0, 0);
        q.push_back(8'h00);
        put16(q, RR_TYPE_NSEC);
        put16(q, 1);
        put16(q, 0);
        put16(q, 0);
        put16(q, 4);
        q.push_back(8'h00);
        q.push_back(8'h01);
        q.push_back(8'h01);
        q.push_back(8'h40);
        queue_datagram(q, 0);
        q.delete();
        // Unknown type whose length runs past the end: fine if nothing more is read.
        put_header(q, 16'h3000, 16'h8400, 0, 1, 0, 0);
        q.push_back(8'h00);
        put16(q, 16'h00ff);
        put16(q, 1);
        put16(q, 0);
        put16(q, 0);
        put16(q, 16'hffff);
        queue_datagram(q, 0);
        q[7] = 8'h02;                                     // same, then a second record
        queue_datagram(q, 0);
        q.delete();
        // TXT: key without separator, empty entry ending the data, SRV ports.
        put_header(q, 16'h4000, 16'h8400, 0, 3, 0, 0);
        q.push_back(8'h00);
        put16(q, RR_TYPE_TXT);
        put16(q, 1);
        put16(q, 0);
        put16(q, 0);
        put16(q, 1 + key_len_reg + 2);
        q.push_back(8'(key_len_reg));
        for (int i = 0; i < key_len_reg; i++) q.push_back(key_at(i));
        q.push_back(8'h00);
        q.push_back(8'h00);
        q.push_back(8'hc0);
        q.push_back(8'h0c);
        put16(q, RR_TYPE_SRV);
        put16(q, 1);
        put16(q, 0);
        put16(q, 0);
        put16(q, 7);
        put16(q, 0);
        put16(q, 0);
        put16(q, 16'hffff);
        q.push_back(8'h00);
        q.push_back(8'h00);
        put16(q, RR_TYPE_SRV);
        put16(q, 1);
        put16(q, 0);
        put16(q, 0);
        put16(q, 7);
        put16(q, 0);
        put16(q, 0);
        put16(q, 0);
        q.push_back(8'h00);
        queue_datagram(q, 0);
    endtask

    // ---------------------------------------------------------------- driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 0;
            send_gap <= 0;
        end else begin
            if (s_valid && s_ready) begin
                rx_bytes.push_back(s_packet_byte);
                if (s_last_byte) begin
                    pending_results.push_back(predict_datagram());
                    rx_bytes.delete();
                    datagrams_sent++;
                end
                void'(tx_q.pop_front());
            end
            if (!(s_valid && !s_ready)) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_valid <= 0;
                end else if (tx_q.size() > 0 && !(tx_q[0].hold && pending_results.size() != 0))
                begin
                    if (!quiet && $urandom_range(0, 9) == 0) begin
                        send_gap <= $urandom_range(0, 17);
                        s_valid <= 0;
                    end else begin
                        s_valid <= 1;
                        s_packet_byte <= tx_q[0].data;
                        s_last_byte <= tx_q[0].last;
                    end
                end else begin
                    s_valid <= 0;
                end
            end
        end
    end

    // ---------------------------------------------------------------- monitor
    function automatic void check_field(string name, int expv, int actv);
        if (expv != actv) begin
            $error("%s mismatch: expected %0h, got %0h", name, expv, actv);
            fail_count++;
        end
    endfunction

    always @(posedge aclk) begin
        dns_result_t e;
        if (!aresetn) begin
            m_ready <= 0;
            recv_gap <= 0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (pending_results.size() == 0) begin
                    $error("result transaction with no datagram outstanding");
                    fail_count++;
                end else begin
                    e = pending_results.pop_front();
                    ok_seen += e.ok;
                    match_seen += e.attr;
                    check_field("parse_ok", e.ok, m_parse_ok);
                    check_field("transaction_id", e.id, m_transaction_id);
                    check_field("is_response", e.resp, m_is_response);
                    check_field("is_truncated", e.trunc, m_is_truncated);
                    check_field("service_port", e.port, m_service_port);
                    check_field("attribute_match", e.attr, m_attribute_match);
                    check_field("too_long", e.too_long, m_too_long);
                end
            end
            if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_ready <= 0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                recv_gap <= $urandom_range(0, 17);
                m_ready <= 0;
            end else begin
                m_ready <= 1;
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // ---------------------------------------------------------------- sequencing
    task automatic write_reg(logic [2:0] idx, logic [63:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 0;
        case (idx)
            CFG_MATCH_KEY:        key_reg = val;
            CFG_MATCH_KEY_LEN:    key_len_reg = val[3:0];
            CFG_MATCH_VALUE_HIGH: val_hi_reg = val;
            CFG_MATCH_VALUE_LOW:  val_lo_reg = val;
            CFG_MATCH_VALUE_LEN:  val_len_reg = val[4:0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (tx_q.size() != 0 || s_valid || pending_results.size() != 0) @(posedge aclk);
        repeat (64) @(posedge aclk);
    endtask

    function automatic logic [63:0] letters();
        logic [63:0] w;
        for (int i = 0; i < 8; i++) w[8 * i +: 8] = 8'(8'h61 + $urandom_range(0, 25));
        return w;
    endfunction

    task automatic configure(logic [63:0] k, int kl, logic [63:0] vh, logic [63:0] vl, int vl_n);
        write_reg(CFG_MATCH_KEY, k);
        write_reg(CFG_MATCH_KEY_LEN, 64'(kl));
        write_reg(CFG_MATCH_VALUE_HIGH, vh);
        write_reg(CFG_MATCH_VALUE_LOW, vl);
        write_reg(CFG_MATCH_VALUE_LEN, 64'(vl_n));
    endtask

    task automatic random_phase(int byte_budget, bit with_hold);
        int start;
        start = tx_q.size();
        while (tx_q.size() - start < byte_budget)
            random_datagram(with_hold && tx_q.size() - start > byte_budget / 2 &&
                            $urandom_range(0, 3) == 0);
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        random_phase(100, 0);
        wait_drained();

        configure(letters(), 3, letters(), letters(), 4);
        directed_datagrams();
        random_phase(200, 0);
        wait_drained();

        configure(letters(), 8, letters(), letters(), 16);
        random_phase(250, 1);
        wait_drained();

        configure(64'hffff_ffff_ffff_ffff, 15, 64'hffff_ffff_ffff_ffff,
                  64'hffff_ffff_ffff_ffff, 31);
        random_phase(150, 0);
        wait_drained();

        configure(letters(), 1, 64'h0, 64'h0, 0);
        random_phase(200, 0);
        wait_drained();

        configure(64'h0, 0, letters(), letters(), 16);
        random_phase(150, 0);
        wait_drained();

        configure(letters(), $urandom_range(1, 8), letters(), letters(), $urandom_range(0, 16));
        quiet = 1;
        random_phase(200, 0);
        wait_drained();
        repeat (200) @(posedge aclk);

        $display("Covered %0d datagrams over seven register settings: %0d results checked,",
                 datagrams_sent, results_seen);
        $display("%0d parsed cleanly and %0d matched the wanted attribute.", ok_seen, match_seen);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

### dns_response_parser_unit.f
design/drp_pkg.sv
design/drp_front.sv
design/drp_queue.sv
design/drp_back.sv
design/dns_response_parser_unit.sv
design/drp_checker.sv
dv/tb_top.sv
